// ===== hdl/ppra_pkg.sv =====
// Shared types, codes and constants for the physical page region allocator.
// No dependencies; used by ppra_ctrl, ppra_dp and the top level.
package ppra_pkg;

    localparam int OP_W    = 2;
    localparam int TYPE_W  = 32;
    localparam int ADDR_W  = 52;
    localparam int SIZE_W  = 53;
    localparam int PAGES_W = 41;
    localparam int ST_W    = 2;
    localparam int CFG_W   = 2;
    localparam int PIECES  = 4;
    localparam int SLOT_W  = 2;

    // Item operations
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

    // Result status
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_NOMEM = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_W-1:0] CFG_RSV1_BASE = 2'd0;
    localparam logic [CFG_W-1:0] CFG_RSV1_END  = 2'd1;
    localparam logic [CFG_W-1:0] CFG_RSV2_BASE = 2'd2;
    localparam logic [CFG_W-1:0] CFG_RSV2_END  = 2'd3;

    // Memory descriptor types (UEFI numbering)
    localparam logic [TYPE_W-1:0] MT_RAM_FIRST    = 32'd1;
    localparam logic [TYPE_W-1:0] MT_BS_CODE      = 32'd3;
    localparam logic [TYPE_W-1:0] MT_BS_DATA      = 32'd4;
    localparam logic [TYPE_W-1:0] MT_CONVENTIONAL = 32'd7;
    localparam logic [TYPE_W-1:0] MT_ACPI_RECLAIM = 32'd9;
    localparam logic [TYPE_W-1:0] MT_ACPI_NVS     = 32'd10;
    localparam logic [TYPE_W-1:0] MT_PAL_CODE     = 32'd13;
    localparam logic [TYPE_W-1:0] MT_PERSISTENT   = 32'd14;

    localparam logic [SIZE_W-1:0] ADDR_LIMIT = 53'h10_0000_0000_0000;

    // Controller -> datapath
    typedef struct packed {
        logic              load;
        logic              clear;
        logic              calc_end;
        logic              clip1;
        logic              clip2;
        logic              round;
        logic              store;
        logic [SLOT_W-1:0] slot;
        logic              alloc_init;
        logic              scan;
        logic              update;
        logic              finish;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            free_type;
        logic            hit;
        logic            miss;
        logic            out_ready;
    } t_sts;

    function automatic logic ram_backed(input logic [TYPE_W-1:0] t);
        return (t >= MT_RAM_FIRST && t <= MT_CONVENTIONAL) || t == MT_ACPI_RECLAIM ||
               t == MT_ACPI_NVS || t == MT_PAL_CODE || t == MT_PERSISTENT;
    endfunction

    function automatic logic free_kind(input logic [TYPE_W-1:0] t);
        return t == MT_BS_CODE || t == MT_BS_DATA || t == MT_CONVENTIONAL;
    endfunction

endpackage

// ===== hdl/ppra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ppra_ram #(
    parameter int WIDTH = 105,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== hdl/ppra_ctrl.sv =====
// Sequencing state machine of the region allocator.
// Depends on ppra_pkg (t_cmd, t_sts, operation codes).
module ppra_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ppra_pkg::t_sts  i_sts,
    output ppra_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_CLIP1  = 4'd2;
    localparam logic [3:0] S_CLIP2  = 4'd3;
    localparam logic [3:0] S_ROUND  = 4'd4;
    localparam logic [3:0] S_STORE  = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_UPDATE = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    localparam logic [ppra_pkg::SLOT_W-1:0] LAST_SLOT = ppra_pkg::SLOT_W'(ppra_pkg::PIECES - 1);

    logic [3:0]                  r_state, n_state;
    logic [ppra_pkg::SLOT_W-1:0] r_slot, n_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    ppra_pkg::OP_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_FIN;
                    end
                    ppra_pkg::OP_ADD: begin
                        o_cmd.calc_end = 1'b1;
                        n_state        = S_CLIP1;
                    end
                    ppra_pkg::OP_ALLOC: begin
                        o_cmd.alloc_init = 1'b1;
                        n_state          = S_SCAN;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_CLIP1: begin
                o_cmd.clip1 = 1'b1;
                n_state     = i_sts.free_type ? S_CLIP2 : S_FIN;
            end
            S_CLIP2: begin
                o_cmd.clip2 = 1'b1;
                n_state     = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_slot      = '0;
                n_state     = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                o_cmd.slot  = r_slot;
                n_slot      = r_slot + 1'b1;
                if (r_slot == LAST_SLOT) begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_UPDATE;
                end else if (i_sts.miss) begin
                    n_state = S_FIN;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== hdl/ppra_dp.sv =====
// Datapath of the region allocator: request and config registers, clipping,
// page rounding, region table RAM, first-fit scan and result register.
// Depends on ppra_pkg and ppra_ram.
module ppra_dp #(
    parameter int TABLE_ENTRIES = 256,
    parameter int PAGE_SHIFT    = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppra_pkg::t_cmd                  i_cmd,
    output ppra_pkg::t_sts                  o_sts,
    input  logic [ppra_pkg::OP_W-1:0]       i_operation,
    input  logic [ppra_pkg::TYPE_W-1:0]     i_mem_type,
    input  logic [ppra_pkg::ADDR_W-1:0]     i_phys_start,
    input  logic [ppra_pkg::PAGES_W-1:0]    i_page_count,
    input  logic                            i_cfg_wr,
    input  logic [ppra_pkg::CFG_W-1:0]      i_cfg_index,
    input  logic [ppra_pkg::SIZE_W-1:0]     i_cfg_data,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [ppra_pkg::ST_W-1:0]       o_status,
    output logic [ppra_pkg::ADDR_W-1:0]     o_alloc_addr,
    output logic [ppra_pkg::SIZE_W-1:0]     o_free_bytes,
    output logic [ppra_pkg::SIZE_W-1:0]     o_highest_ram_end
);

    localparam int AW     = ppra_pkg::ADDR_W;
    localparam int SW     = ppra_pkg::SIZE_W;
    localparam int NP     = ppra_pkg::PIECES;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int SHF_W  = ppra_pkg::PAGES_W + PAGE_SHIFT;
    localparam int SUM_W  = ((SHF_W > AW) ? SHF_W : AW) + 1;
    localparam int WORD_W = AW + SW;

    localparam logic [SW-1:0]    PAGE_LSB = (SW'(1) << PAGE_SHIFT) - SW'(1);
    localparam logic [SW-1:0]    FREE_MAX = '1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [SUM_W-1:0] LIMIT_W  = SUM_W'(ppra_pkg::ADDR_LIMIT);

    // request
    logic [ppra_pkg::OP_W-1:0]    r_op;
    logic [ppra_pkg::TYPE_W-1:0]  r_type;
    logic [AW-1:0]                r_start;
    logic [ppra_pkg::PAGES_W-1:0] r_pages;

    // reserved ranges
    logic [SW-1:0] r_rsv1_b, r_rsv1_e, r_rsv2_b, r_rsv2_e;

    // table bookkeeping
    logic [CNT_W-1:0] r_used;
    logic [SW-1:0]    r_free, r_ram_end;

    // add path
    logic [SW-1:0] r_end;
    logic [SW-1:0] r_sub_lo [2];
    logic [SW-1:0] r_sub_hi [2];
    logic [1:0]    r_sub_v;
    logic [SW-1:0] r_pc_lo  [NP];
    logic [SW-1:0] r_pc_hi  [NP];
    logic [NP-1:0] r_pc_v;
    logic [AW-1:0] r_pc_base[NP];
    logic [SW-1:0] r_pc_len [NP];
    logic [NP-1:0] r_pc_ok;

    // allocate path
    logic [SUM_W-1:0] r_want;
    logic [CNT_W-1:0] r_scan_idx;
    logic             r_rd_pend;
    logic [IDX_W-1:0] r_rd_idx, r_hit_idx;
    logic [AW-1:0]    r_hit_start;
    logic [SW-1:0]    r_hit_size;

    // result
    logic [ppra_pkg::ST_W-1:0] r_status;
    logic [AW-1:0]             r_addr;

    // combinational
    logic [SUM_W-1:0] n_sum;
    logic [SW-1:0]    n_end;
    logic             ovl1;
    logic [SW-1:0]    n_sub_lo [2];
    logic [SW-1:0]    n_sub_hi [2];
    logic [1:0]       n_sub_v;
    logic [SW-1:0]    n_pc_lo  [NP];
    logic [SW-1:0]    n_pc_hi  [NP];
    logic [NP-1:0]    n_pc_v;
    logic [AW-1:0]    n_pc_base[NP];
    logic [SW-1:0]    n_pc_len [NP];
    logic [NP-1:0]    n_pc_ok;
    logic             ovl2 [2];
    logic [SW-1:0]    rnd_a [NP];
    logic [SW-1:0]    rnd_b [NP];
    logic [SW:0]      rnd_d [NP];
    logic             full;
    logic [SW:0]      n_free_sum;
    logic [SW-1:0]    want_sz;
    logic             hit, miss, rd_en;
    logic [WORD_W-1:0] rd_word, wr_word;
    logic [AW-1:0]    rd_start;
    logic [SW-1:0]    rd_size;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    // descriptor end, saturated at the address limit
    assign n_sum = SUM_W'(r_start) + (SUM_W'(r_pages) << PAGE_SHIFT);
    assign n_end = (n_sum > LIMIT_W) ? ppra_pkg::ADDR_LIMIT : n_sum[SW-1:0];

    // cut out reserved range one
    always_comb begin
        ovl1        = !(r_end <= r_rsv1_b || SW'(r_start) >= r_rsv1_e);
        n_sub_lo[0] = SW'(r_start);
        n_sub_hi[0] = ovl1 ? r_rsv1_b : r_end;
        n_sub_v[0]  = ovl1 ? (SW'(r_start) < r_rsv1_b) : 1'b1;
        n_sub_lo[1] = r_rsv1_e;
        n_sub_hi[1] = r_end;
        n_sub_v[1]  = ovl1 && (r_end > r_rsv1_e);
    end

    // cut out reserved range two from each sub-range; pieces kept in order
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            ovl2[i]          = !(r_sub_hi[i] <= r_rsv2_b || r_sub_lo[i] >= r_rsv2_e);
            n_pc_lo[2*i]     = r_sub_lo[i];
            n_pc_hi[2*i]     = ovl2[i] ? r_rsv2_b : r_sub_hi[i];
            n_pc_v[2*i]      = r_sub_v[i] && (ovl2[i] ? (r_sub_lo[i] < r_rsv2_b) : 1'b1);
            n_pc_lo[2*i+1]   = r_rsv2_e;
            n_pc_hi[2*i+1]   = r_sub_hi[i];
            n_pc_v[2*i+1]    = r_sub_v[i] && ovl2[i] && (r_sub_hi[i] > r_rsv2_e);
        end
    end

    // narrow each piece inward to whole pages
    always_comb begin
        for (int i = 0; i < NP; i++) begin
            rnd_a[i]     = (r_pc_lo[i] + PAGE_LSB) & ~PAGE_LSB;
            rnd_b[i]     = r_pc_hi[i] & ~PAGE_LSB;
            rnd_d[i]     = {1'b0, rnd_b[i]} - {1'b0, rnd_a[i]};
            n_pc_base[i] = rnd_a[i][AW-1:0];
            n_pc_len[i]  = rnd_d[i][SW-1:0];
            n_pc_ok[i]   = r_pc_v[i] && !rnd_d[i][SW] && (rnd_d[i][SW-1:0] != '0);
        end
    end

    assign full       = (r_used == FULL_CNT);
    assign n_free_sum = {1'b0, r_free} + {1'b0, r_pc_len[i_cmd.slot]};

    // first-fit scan: one RAM read issued per cycle, compared in the cycle after
    assign {rd_start, rd_size} = rd_word;
    assign hit   = r_rd_pend && ({{(SUM_W-SW){1'b0}}, rd_size} >= r_want);
    assign miss  = !r_rd_pend && (r_scan_idx >= r_used);
    assign rd_en = i_cmd.scan && !hit && (r_scan_idx < r_used);
    assign want_sz = r_want[SW-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_used[IDX_W-1:0];
        wr_word = {r_pc_base[i_cmd.slot], r_pc_len[i_cmd.slot]};
        if (i_cmd.update) begin
            wr_en   = 1'b1;
            wr_addr = r_hit_idx;
            wr_word = {r_hit_start + want_sz[AW-1:0], r_hit_size - want_sz};
        end else if (i_cmd.store && r_pc_ok[i_cmd.slot] && !full) begin
            wr_en = 1'b1;
        end
    end

    ppra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_word),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_scan_idx[IDX_W-1:0]),
        .o_rd_data (rd_word)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsv1_b    <= '0;
            r_rsv1_e    <= '0;
            r_rsv2_b    <= '0;
            r_rsv2_e    <= '0;
            r_used      <= '0;
            r_free      <= '0;
            r_ram_end   <= '0;
            r_rd_pend   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    ppra_pkg::CFG_RSV1_BASE: r_rsv1_b <= i_cfg_data;
                    ppra_pkg::CFG_RSV1_END:  r_rsv1_e <= i_cfg_data;
                    ppra_pkg::CFG_RSV2_BASE: r_rsv2_b <= i_cfg_data;
                    ppra_pkg::CFG_RSV2_END:  r_rsv2_e <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_used    <= '0;
                r_free    <= '0;
                r_ram_end <= '0;
            end
            if (i_cmd.clip1 && ppra_pkg::ram_backed(r_type) && (r_end > r_ram_end)) begin
                r_ram_end <= r_end;
            end
            if (i_cmd.store && r_pc_ok[i_cmd.slot] && !full) begin
                r_used <= r_used + 1'b1;
                r_free <= n_free_sum[SW] ? FREE_MAX : n_free_sum[SW-1:0];
            end
            if (i_cmd.update) begin
                r_free <= (r_free >= want_sz) ? r_free - want_sz : '0;
            end
            if (i_cmd.alloc_init) begin
                r_rd_pend <= 1'b0;
            end else if (i_cmd.scan && !hit) begin
                r_rd_pend <= (r_scan_idx < r_used);
            end
            if (i_cmd.finish) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_operation;
            r_type   <= i_mem_type;
            r_start  <= i_phys_start;
            r_pages  <= i_page_count;
            r_status <= ppra_pkg::ST_OK;
            r_addr   <= '0;
        end
        if (i_cmd.calc_end) begin
            r_end <= n_end;
        end
        if (i_cmd.clip1) begin
            r_sub_lo <= n_sub_lo;
            r_sub_hi <= n_sub_hi;
            r_sub_v  <= n_sub_v;
        end
        if (i_cmd.clip2) begin
            r_pc_lo <= n_pc_lo;
            r_pc_hi <= n_pc_hi;
            r_pc_v  <= n_pc_v;
        end
        if (i_cmd.round) begin
            r_pc_base <= n_pc_base;
            r_pc_len  <= n_pc_len;
            r_pc_ok   <= n_pc_ok;
        end
        if (i_cmd.store && r_pc_ok[i_cmd.slot] && full) begin
            r_status <= ppra_pkg::ST_FULL;
        end
        if (i_cmd.alloc_init) begin
            r_want     <= SUM_W'(r_pages) << PAGE_SHIFT;
            r_scan_idx <= '0;
        end
        if (rd_en) begin
            r_rd_idx   <= r_scan_idx[IDX_W-1:0];
            r_scan_idx <= r_scan_idx + 1'b1;
        end
        if (i_cmd.scan && hit) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_start <= rd_start;
            r_hit_size  <= rd_size;
        end
        if (i_cmd.scan && miss) begin
            r_status <= ppra_pkg::ST_NOMEM;
        end
        if (i_cmd.update) begin
            r_addr <= r_hit_start;
        end
        if (i_cmd.finish) begin
            o_status          <= r_status;
            o_alloc_addr      <= r_addr;
            o_free_bytes      <= r_free;
            o_highest_ram_end <= r_ram_end;
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.free_type = ppra_pkg::free_kind(r_type);
    assign o_sts.hit       = hit;
    assign o_sts.miss      = miss;
    assign o_sts.out_ready = !o_out_valid || !i_out_stall;

endmodule

// ===== hdl/physical_page_region_allocator.sv =====
// Top level of the physical page region allocator.
// Depends on ppra_pkg, ppra_ctrl, ppra_dp (and ppra_ram below it).
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | to block  | i_in_valid / o_in_stall | operation, mem_type, phys_start, page_count
//  out     | from block| o_out_valid / i_out_stall| status, alloc_addr, free_bytes,
//          |           |                         | highest_ram_end
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| cfg_index, cfg_data (reserved ranges)
//
// One request is worked at a time; o_in_stall is low only when the
// sequencer is idle. From accept to result register: a clear goes to
// the final step, an add of a non-free type takes one clip step, an add
// of a free type two clip steps, a rounding step and one table write
// slot per piece, an allocate reads entries up to and including the hit
// (at most regions_used) and updates it. The scan reads one region table
// entry per cycle through the RAM's single registered read port.
// A finished result sits in the output register; the next request is
// taken while it waits, and the sequencer holds in its final step only if
// the result of the next request is ready before the old one is taken.
// Reset (synchronous, active low) empties the table at once: the region
// RAM is never cleared, only entries below the used count are read.
// Config writes are taken every cycle and must only occur while idle.
module physical_page_region_allocator #(
    parameter int TABLE_ENTRIES = 256,
    parameter int PAGE_SHIFT    = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ppra_pkg::OP_W-1:0]       i_operation,
    input  logic [ppra_pkg::TYPE_W-1:0]     i_mem_type,
    input  logic [ppra_pkg::ADDR_W-1:0]     i_phys_start,
    input  logic [ppra_pkg::PAGES_W-1:0]    i_page_count,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ppra_pkg::ST_W-1:0]       o_status,
    output logic [ppra_pkg::ADDR_W-1:0]     o_alloc_addr,
    output logic [ppra_pkg::SIZE_W-1:0]     o_free_bytes,
    output logic [ppra_pkg::SIZE_W-1:0]     o_highest_ram_end,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ppra_pkg::CFG_W-1:0]      i_cfg_index,
    input  logic [ppra_pkg::SIZE_W-1:0]     i_cfg_data
);

    ppra_pkg::t_cmd cmd;
    ppra_pkg::t_sts sts;

    // Reserved-range registers are plain flops: always ready.
    assign o_cfg_ready = 1'b1;

    ppra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ppra_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .PAGE_SHIFT    (PAGE_SHIFT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_operation       (i_operation),
        .i_mem_type        (i_mem_type),
        .i_phys_start      (i_phys_start),
        .i_page_count      (i_page_count),
        .i_cfg_wr          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_alloc_addr      (o_alloc_addr),
        .o_free_bytes      (o_free_bytes),
        .o_highest_ram_end (o_highest_ram_end)
    );

    // An accepted request keeps the sequencer busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request port open right after an accept");

    // Only a successful allocate carries a nonzero address.
    a_addr_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alloc_addr != '0) |-> (o_status == ppra_pkg::ST_OK))
        else $error("nonzero address with an error status");

    // Descriptor ends are saturated at the address limit.
    a_ram_end_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_highest_ram_end <= ppra_pkg::ADDR_LIMIT))
        else $error("highest RAM end above address limit");

endmodule
